/* design/kbl_pkg.sv */
package kbl_pkg;

   localparam int unsigned CntWidth   = 9;
   localparam int unsigned TimerWidth = 16;
   localparam int unsigned CsrWidth   = 16;
   localparam int unsigned CsrIdxWidth = 2;

   localparam logic [7:0] InvMask = 8'hFF;

   localparam logic [CntWidth-1:0]   MaxBlockReset   = 9'd64;
   localparam logic [TimerWidth-1:0] FirstTmoReset   = 16'd2000;
   localparam logic [TimerWidth-1:0] ByteTmoReset    = 16'd1000;

   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_MAX_BLOCK = 2'd0,
      CSR_FIRST_TMO = 2'd1,
      CSR_BYTE_TMO  = 2'd2
   } csr_idx_type;

   typedef enum logic [1:0] {
      OP_START = 2'd0,
      OP_RX    = 2'd1,
      OP_TICK  = 2'd2,
      OP_SEND  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      MODE_IDLE = 2'd0,
      MODE_RECV = 2'd1,
      MODE_ECHO = 2'd2
   } mode_type;

   typedef enum logic [2:0] {
      ST_IDLE     = 3'd0,
      ST_PROGRESS = 3'd1,
      ST_DONE     = 3'd2,
      ST_CNT_ERR  = 3'd3,
      ST_ECHO_ERR = 3'd4,
      ST_TIMEOUT  = 3'd5,
      ST_TOO_LONG = 3'd6,
      ST_IGNORED  = 3'd7
   } status_type;

   typedef struct packed {
      logic [1:0]          op;
      logic [7:0]          line_byte;
      logic [CntWidth-1:0] expected_size;
      logic [7:0]          send_data;
      logic                send_last;
   } req_type;

   typedef struct packed {
      logic       tx_valid;
      logic [7:0] tx_byte;
      logic       rx_valid;
      logic [7:0] rx_byte;
      logic       rx_last;
      logic [2:0] status;
      logic [7:0] block_count;
   } rsp_type;

   typedef struct packed {
      logic [CntWidth-1:0]   max_block_bytes;
      logic [TimerWidth-1:0] first_byte_timeout_ms;
      logic [TimerWidth-1:0] byte_timeout_ms;
   } cfg_type;

endpackage

/* design/kbl_if.sv */
interface kbl_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] op;
   logic [7:0] line_byte;
   logic [8:0] expected_size;
   logic [7:0] send_data;
   logic       send_last;

   modport source (output valid, op, line_byte, expected_size, send_data, send_last,
                   input ready);
   modport sink   (input valid, op, line_byte, expected_size, send_data, send_last,
                   output ready);
endinterface

interface kbl_rsp_if;
   logic       valid;
   logic       ready;
   logic       tx_valid;
   logic [7:0] tx_byte;
   logic       rx_valid;
   logic [7:0] rx_byte;
   logic       rx_last;
   logic [2:0] status;
   logic [7:0] block_count;

   modport source (output valid, tx_valid, tx_byte, rx_valid, rx_byte, rx_last, status,
                   block_count, input ready);
   modport sink   (input valid, tx_valid, tx_byte, rx_valid, rx_byte, rx_last, status,
                   block_count, output ready);
endinterface

/* design/keyword_block_link_engine.sv */
// Block link layer for a byte-oriented diagnostic serial line.
// req_chan carries one event per beat: start receive, line byte, millisecond
// tick or send byte. rsp_chan returns exactly one result beat per request beat,
// in order: bytes to drive onto the line, received block bytes, status and the
// block counter.
// A request accepted from req_chan is registered in the request register,
// evaluated against the link state by combinational logic, and its result is
// registered in the result register, which drives rsp_chan.
// Throughput: one beat per cycle while rsp_chan does not stall; the link state
// update for an event is combinational logic between the two registers.
// csr_we/csr_index/csr_wdata write the limits and timeouts; write them only
// while no beat is in flight.
// Reset clears the link to idle, the block counter to zero and restores the
// register defaults (64 bytes, 2000 ms, 1000 ms).
// When rsp_chan stalls, the result register holds and the request register
// takes one more beat; after that req_chan.ready drops until the sink takes
// the pending result.
module keyword_block_link_engine (
   input  logic                             clock,
   input  logic                             reset,
   kbl_req_if.sink                          req_chan,
   kbl_rsp_if.source                        rsp_chan,
   input  logic                             csr_we,
   input  logic [kbl_pkg::CsrIdxWidth-1:0]  csr_index,
   input  logic [kbl_pkg::CsrWidth-1:0]     csr_wdata
);

   kbl_pkg::cfg_type cfg;
   kbl_pkg::req_type req_ff, req_in;
   kbl_pkg::rsp_type rsp_ff, step_rsp;
   logic             req_valid_ff, req_valid_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             advance;
   logic             req_take;

   kbl_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   kbl_core u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .item    (req_ff),
      .cfg     (cfg),
      .result  (step_rsp)
   );

   assign advance        = req_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !req_valid_ff || advance;
   assign req_take       = req_chan.valid && req_chan.ready;

   always_comb begin
      req_in.op            = req_chan.op;
      req_in.line_byte     = req_chan.line_byte;
      req_in.expected_size = req_chan.expected_size;
      req_in.send_data     = req_chan.send_data;
      req_in.send_last     = req_chan.send_last;
      req_valid_in = req_take ? 1'b1 : (advance ? 1'b0 : req_valid_ff);
      rsp_valid_in = advance ? 1'b1 : ((rsp_valid_ff && !rsp_chan.ready) ? 1'b1 : 1'b0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         req_ff <= req_in;
      end
      if (advance) begin
         rsp_ff <= step_rsp;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.tx_valid    = rsp_ff.tx_valid;
   assign rsp_chan.tx_byte     = rsp_ff.tx_byte;
   assign rsp_chan.rx_valid    = rsp_ff.rx_valid;
   assign rsp_chan.rx_byte     = rsp_ff.rx_byte;
   assign rsp_chan.rx_last     = rsp_ff.rx_last;
   assign rsp_chan.status      = rsp_ff.status;
   assign rsp_chan.block_count = rsp_ff.block_count;

endmodule

/* design/kbl_csr.sv */
module kbl_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [kbl_pkg::CsrIdxWidth-1:0]      csr_index,
   input  logic [kbl_pkg::CsrWidth-1:0]         csr_wdata,
   output kbl_pkg::cfg_type                     cfg
);

   kbl_pkg::cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            kbl_pkg::CSR_MAX_BLOCK:
               cfg_in.max_block_bytes = csr_wdata[kbl_pkg::CntWidth-1:0];
            kbl_pkg::CSR_FIRST_TMO:
               cfg_in.first_byte_timeout_ms = csr_wdata[kbl_pkg::TimerWidth-1:0];
            kbl_pkg::CSR_BYTE_TMO:
               cfg_in.byte_timeout_ms = csr_wdata[kbl_pkg::TimerWidth-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_block_bytes       <= kbl_pkg::MaxBlockReset;
         cfg_ff.first_byte_timeout_ms <= kbl_pkg::FirstTmoReset;
         cfg_ff.byte_timeout_ms       <= kbl_pkg::ByteTmoReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* design/kbl_core.sv */
module kbl_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             step_en,
   input  kbl_pkg::req_type item,
   input  kbl_pkg::cfg_type cfg,
   output kbl_pkg::rsp_type result
);

   localparam int unsigned CW = kbl_pkg::CntWidth;
   localparam int unsigned TW = kbl_pkg::TimerWidth;

   logic [7:0]       block_counter_ff, block_counter_in;
   kbl_pkg::mode_type link_mode_ff, link_mode_in;
   logic [CW-1:0]    received_count_ff, received_count_in;
   logic [CW-1:0]    target_size_ff, target_size_in;
   logic             length_mode_ff, length_mode_in;
   logic [TW-1:0]    timeout_left_ff, timeout_left_in;
   logic [7:0]       sent_byte_ff, sent_byte_in;

   logic             fail;
   kbl_pkg::status_type st;

   always_comb begin
      block_counter_in  = block_counter_ff;
      link_mode_in      = link_mode_ff;
      received_count_in = received_count_ff;
      target_size_in    = target_size_ff;
      length_mode_in    = length_mode_ff;
      timeout_left_in   = timeout_left_ff;
      sent_byte_in      = sent_byte_ff;
      fail              = 1'b0;
      st                = kbl_pkg::ST_IGNORED;
      result            = '0;

      case (kbl_pkg::op_type'(item.op))
         kbl_pkg::OP_START: begin
            if (item.expected_size > cfg.max_block_bytes) begin
               link_mode_in = kbl_pkg::MODE_IDLE;
               st = kbl_pkg::ST_TOO_LONG;
            end else begin
               link_mode_in      = kbl_pkg::MODE_RECV;
               received_count_in = '0;
               target_size_in    = item.expected_size;
               length_mode_in    = (item.expected_size == '0);
               timeout_left_in   = cfg.first_byte_timeout_ms;
               st = kbl_pkg::ST_PROGRESS;
            end
         end
         kbl_pkg::OP_RX: begin
            if (link_mode_ff == kbl_pkg::MODE_RECV) begin
               received_count_in = received_count_ff + CW'(1);
               if (length_mode_ff && received_count_in == CW'(1)) begin
                  target_size_in = {1'b0, item.line_byte} + CW'(1);
                  if (target_size_in > cfg.max_block_bytes) begin
                     fail = 1'b1;
                     st = kbl_pkg::ST_TOO_LONG;
                  end
               end
               if (!fail && length_mode_ff && received_count_in == CW'(2) &&
                   item.line_byte != block_counter_ff) begin
                  fail = 1'b1;
                  st = kbl_pkg::ST_CNT_ERR;
               end
               if (fail) begin
                  link_mode_in = kbl_pkg::MODE_IDLE;
               end else begin
                  if ((!length_mode_ff && received_count_in == target_size_in) ||
                      (length_mode_ff && received_count_in < target_size_in)) begin
                     result.tx_valid = 1'b1;
                     result.tx_byte  = item.line_byte ^ kbl_pkg::InvMask;
                  end
                  result.rx_valid = 1'b1;
                  result.rx_byte  = item.line_byte;
                  timeout_left_in = cfg.byte_timeout_ms;
                  if (received_count_in == target_size_in) begin
                     result.rx_last   = 1'b1;
                     block_counter_in = block_counter_ff + 8'd1;
                     link_mode_in     = kbl_pkg::MODE_IDLE;
                     st = kbl_pkg::ST_DONE;
                  end else begin
                     st = kbl_pkg::ST_PROGRESS;
                  end
               end
            end else if (link_mode_ff == kbl_pkg::MODE_ECHO) begin
               link_mode_in = kbl_pkg::MODE_IDLE;
               st = (item.line_byte == (sent_byte_ff ^ kbl_pkg::InvMask)) ?
                    kbl_pkg::ST_PROGRESS : kbl_pkg::ST_ECHO_ERR;
            end else begin
               st = kbl_pkg::ST_IGNORED;
            end
         end
         kbl_pkg::OP_TICK: begin
            if (link_mode_ff == kbl_pkg::MODE_IDLE) begin
               st = kbl_pkg::ST_IDLE;
            end else if (timeout_left_ff <= TW'(1)) begin
               timeout_left_in = '0;
               link_mode_in    = kbl_pkg::MODE_IDLE;
               st = kbl_pkg::ST_TIMEOUT;
            end else begin
               timeout_left_in = timeout_left_ff - TW'(1);
               st = kbl_pkg::ST_PROGRESS;
            end
         end
         kbl_pkg::OP_SEND: begin
            if (link_mode_ff == kbl_pkg::MODE_IDLE) begin
               result.tx_valid = 1'b1;
               result.tx_byte  = item.send_data;
               sent_byte_in    = item.send_data;
               if (item.send_last) begin
                  block_counter_in = block_counter_ff + 8'd1;
                  st = kbl_pkg::ST_DONE;
               end else begin
                  link_mode_in    = kbl_pkg::MODE_ECHO;
                  timeout_left_in = cfg.byte_timeout_ms;
                  st = kbl_pkg::ST_PROGRESS;
               end
            end else begin
               st = kbl_pkg::ST_IGNORED;
            end
         end
         default: st = kbl_pkg::ST_IGNORED;
      endcase

      result.status      = st;
      result.block_count = block_counter_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         block_counter_ff  <= '0;
         link_mode_ff      <= kbl_pkg::MODE_IDLE;
         received_count_ff <= '0;
         target_size_ff    <= '0;
         length_mode_ff    <= 1'b0;
         timeout_left_ff   <= '0;
         sent_byte_ff      <= '0;
      end else if (step_en) begin
         block_counter_ff  <= block_counter_in;
         link_mode_ff      <= link_mode_in;
         received_count_ff <= received_count_in;
         target_size_ff    <= target_size_in;
         length_mode_ff    <= length_mode_in;
         timeout_left_ff   <= timeout_left_in;
         sent_byte_ff      <= sent_byte_in;
      end
   end

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps
module tb;

   typedef struct packed {
      logic [7:0]        counter;
      kbl_pkg::mode_type mode;
      logic [8:0]        rcvd;
      logic [8:0]        target;
      logic              len_mode;
      logic [15:0]       tmo_left;
      logic [7:0]        sent;
      logic              sent_last;
   } link_state_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                            csr_we;
   logic [kbl_pkg::CsrIdxWidth-1:0] csr_index;
   logic [kbl_pkg::CsrWidth-1:0]    csr_wdata;

   kbl_req_if req_chan ();
   kbl_rsp_if rsp_chan ();

   keyword_block_link_engine DUT (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   link_state_type   gen_link;
   link_state_type   dut_link;
   kbl_pkg::cfg_type gen_limits;
   kbl_pkg::cfg_type dut_limits;

   kbl_pkg::req_type link_events[$];
   kbl_pkg::rsp_type link_results[$];

   int   made = 0;
   int   fail_count = 0;
   int   feed_mode = 0;
   int   drain_mode = 0;
   int   gap_left = 0;
   int   burst_left = 0;
   int   stall_left = 0;
   int   flow_left = 0;
   logic req_beat_taken = 1'b0;

   kbl_pkg::req_type next_req;
   kbl_pkg::req_type seen_req;
   kbl_pkg::rsp_type want_rsp;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void link_reset(output link_state_type s, output kbl_pkg::cfg_type c);
      s = '0;
      s.mode = kbl_pkg::MODE_IDLE;
      c.max_block_bytes = kbl_pkg::MaxBlockReset;
      c.first_byte_timeout_ms = kbl_pkg::FirstTmoReset;
      c.byte_timeout_ms = kbl_pkg::ByteTmoReset;
   endfunction

   function automatic kbl_pkg::rsp_type link_step(inout link_state_type s,
                                                  input kbl_pkg::cfg_type c,
                                                  input kbl_pkg::req_type r);
      kbl_pkg::rsp_type o;
      logic             fail;
      o = '0;
      o.status = kbl_pkg::ST_IGNORED;
      fail = 1'b0;
      case (r.op)
         kbl_pkg::OP_START: begin
            if (r.expected_size > c.max_block_bytes) begin
               s.mode = kbl_pkg::MODE_IDLE;
               o.status = kbl_pkg::ST_TOO_LONG;
            end else begin
               s.mode = kbl_pkg::MODE_RECV;
               s.rcvd = '0;
               s.target = r.expected_size;
               s.len_mode = (r.expected_size == '0);
               s.tmo_left = c.first_byte_timeout_ms;
               o.status = kbl_pkg::ST_PROGRESS;
            end
         end
         kbl_pkg::OP_RX: begin
            if (s.mode == kbl_pkg::MODE_RECV) begin
               s.rcvd = s.rcvd + 9'd1;
               if (s.len_mode && s.rcvd == 9'd1) begin
                  s.target = {1'b0, r.line_byte} + 9'd1;
                  if (s.target > c.max_block_bytes) begin
                     fail = 1'b1;
                     o.status = kbl_pkg::ST_TOO_LONG;
                  end
               end
               if (!fail && s.len_mode && s.rcvd == 9'd2 && r.line_byte != s.counter) begin
                  fail = 1'b1;
                  o.status = kbl_pkg::ST_CNT_ERR;
               end
               if (fail) begin
                  s.mode = kbl_pkg::MODE_IDLE;
               end else begin
                  if ((!s.len_mode && s.rcvd == s.target) ||
                      (s.len_mode && s.rcvd < s.target)) begin
                     o.tx_valid = 1'b1;
                     o.tx_byte = r.line_byte ^ kbl_pkg::InvMask;
                  end
                  o.rx_valid = 1'b1;
                  o.rx_byte = r.line_byte;
                  s.tmo_left = c.byte_timeout_ms;
                  if (s.rcvd == s.target) begin
                     o.rx_last = 1'b1;
                     s.counter = s.counter + 8'd1;
                     s.mode = kbl_pkg::MODE_IDLE;
                     o.status = kbl_pkg::ST_DONE;
                  end else begin
                     o.status = kbl_pkg::ST_PROGRESS;
                  end
               end
            end else if (s.mode == kbl_pkg::MODE_ECHO) begin
               s.mode = kbl_pkg::MODE_IDLE;
               o.status = (r.line_byte == (s.sent ^ kbl_pkg::InvMask)) ?
                          kbl_pkg::ST_PROGRESS : kbl_pkg::ST_ECHO_ERR;
            end
         end
         kbl_pkg::OP_TICK: begin
            if (s.mode == kbl_pkg::MODE_IDLE) begin
               o.status = kbl_pkg::ST_IDLE;
            end else if (s.tmo_left <= 16'd1) begin
               s.tmo_left = '0;
               s.mode = kbl_pkg::MODE_IDLE;
               o.status = kbl_pkg::ST_TIMEOUT;
            end else begin
               s.tmo_left = s.tmo_left - 16'd1;
               o.status = kbl_pkg::ST_PROGRESS;
            end
         end
         default: begin
            if (s.mode == kbl_pkg::MODE_IDLE) begin
               o.tx_valid = 1'b1;
               o.tx_byte = r.send_data;
               s.sent = r.send_data;
               s.sent_last = r.send_last;
               if (r.send_last) begin
                  s.counter = s.counter + 8'd1;
                  o.status = kbl_pkg::ST_DONE;
               end else begin
                  s.mode = kbl_pkg::MODE_ECHO;
                  s.tmo_left = c.byte_timeout_ms;
                  o.status = kbl_pkg::ST_PROGRESS;
               end
            end
         end
      endcase
      o.block_count = s.counter;
      return o;
   endfunction

   task automatic note(input string msg);
      if (fail_count < 40)
         $display("%0t: %s", $time, msg);
      fail_count++;
   endtask

   task automatic check_field(input string name, input logic [8:0] got, input logic [8:0] want);
      if (got !== want)
         note($sformatf("%s got %0h expected %0h", name, got, want));
   endtask

   // ---------------- stimulus generation ----------------

   function automatic kbl_pkg::req_type rand_req(input kbl_pkg::op_type op);
      kbl_pkg::req_type r;
      r.op = op;
      r.line_byte = 8'($urandom_range(0, 255));
      r.expected_size = 9'($urandom_range(0, 511));
      r.send_data = 8'($urandom_range(0, 255));
      r.send_last = 1'($urandom_range(0, 1));
      return r;
   endfunction

   task automatic put_req(input kbl_pkg::req_type r);
      void'(link_step(gen_link, gen_limits, r));
      link_events.push_back(r);
      made++;
   endtask

   task automatic put_op(input kbl_pkg::op_type op, input logic [7:0] b, input logic [8:0] n);
      kbl_pkg::req_type r;
      r = rand_req(op);
      r.line_byte = b;
      r.send_data = b;
      r.expected_size = n;
      r.send_last = n[0];
      put_req(r);
   endtask

   task automatic gen_ticks();
      int n;
      if ($urandom_range(0, 9) < 3) begin
         n = $urandom_range(1, 3);
         repeat (n) put_req(rand_req(kbl_pkg::OP_TICK));
      end
   endtask

   task automatic gen_length_block();
      int unsigned      mx;
      int unsigned      len_byte;
      kbl_pkg::req_type r;
      mx = gen_limits.max_block_bytes;
      put_req(rand_req(kbl_pkg::OP_START));
      gen_link.len_mode = gen_link.len_mode;
      if (gen_link.mode != kbl_pkg::MODE_RECV)
         return;
      gen_ticks();
      if ($urandom_range(0, 9) == 0)
         len_byte = $urandom_range(0, 255);
      else if ($urandom_range(0, 29) == 0)
         len_byte = mx - 1;
      else
         len_byte = $urandom_range(0, (mx > 8) ? 7 : mx - 1);
      r = rand_req(kbl_pkg::OP_RX);
      r.line_byte = len_byte[7:0];
      put_req(r);
      for (int i = 2; i <= len_byte + 1; i++) begin
         if (gen_link.mode != kbl_pkg::MODE_RECV)
            break;
         gen_ticks();
         if (gen_link.mode != kbl_pkg::MODE_RECV)
            break;
         r = rand_req(kbl_pkg::OP_RX);
         if (i == 2 && $urandom_range(0, 9) != 0)
            r.line_byte = gen_link.counter;
         put_req(r);
      end
   endtask

   task automatic gen_fixed_block();
      int unsigned      mx;
      int unsigned      sel;
      int unsigned      es;
      kbl_pkg::req_type r;
      mx = gen_limits.max_block_bytes;
      sel = $urandom_range(0, 19);
      if (sel == 0)
         es = $urandom_range(mx + 1, 511);
      else if (sel == 1)
         es = mx;
      else
         es = $urandom_range(1, (mx > 8) ? 8 : mx);
      r = rand_req(kbl_pkg::OP_START);
      r.expected_size = es[8:0];
      put_req(r);
      for (int i = 0; i < es; i++) begin
         if (gen_link.mode != kbl_pkg::MODE_RECV)
            break;
         gen_ticks();
         if (gen_link.mode != kbl_pkg::MODE_RECV)
            break;
         put_req(rand_req(kbl_pkg::OP_RX));
      end
   endtask

   task automatic gen_send_block();
      int               n;
      kbl_pkg::req_type r;
      n = $urandom_range(0, 3);
      repeat (n) begin
         r = rand_req(kbl_pkg::OP_SEND);
         r.send_last = 1'b0;
         put_req(r);
         gen_ticks();
         if (gen_link.mode == kbl_pkg::MODE_ECHO) begin
            r = rand_req(kbl_pkg::OP_RX);
            if ($urandom_range(0, 9) != 0)
               r.line_byte = gen_link.sent ^ kbl_pkg::InvMask;
            put_req(r);
         end
      end
      r = rand_req(kbl_pkg::OP_SEND);
      r.send_last = 1'b1;
      put_req(r);
   endtask

   task automatic gen_timeout_run();
      int               n;
      kbl_pkg::req_type r;
      if ($urandom_range(0, 1)) begin
         r = rand_req(kbl_pkg::OP_START);
         r.expected_size = 9'($urandom_range(0, gen_limits.max_block_bytes));
      end else begin
         r = rand_req(kbl_pkg::OP_SEND);
         r.send_last = 1'b0;
      end
      put_req(r);
      n = (gen_link.tmo_left == '0) ? 1 : gen_link.tmo_left;
      if (n > 40)
         n = $urandom_range(1, 5);
      n = n + $urandom_range(0, 1);
      repeat (n) put_req(rand_req(kbl_pkg::OP_TICK));
   endtask

   task automatic gen_sequence();
      int unsigned kind;
      int          n;
      kind = $urandom_range(0, 99);
      if (kind < 30) begin
         gen_length_block();
      end else if (kind < 50) begin
         gen_fixed_block();
      end else if (kind < 75) begin
         gen_send_block();
      end else if (kind < 85) begin
         gen_timeout_run();
      end else begin
         n = $urandom_range(1, 4);
         repeat (n) put_req(rand_req(kbl_pkg::op_type'($urandom_range(0, 3))));
      end
   endtask

   task automatic wait_drained();
      while (link_events.size() != 0 || req_chan.valid || link_results.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic csr_write(input kbl_pkg::csr_idx_type idx, input logic [15:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         kbl_pkg::CSR_MAX_BLOCK: begin
            gen_limits.max_block_bytes = value[8:0];
            dut_limits.max_block_bytes = value[8:0];
         end
         kbl_pkg::CSR_FIRST_TMO: begin
            gen_limits.first_byte_timeout_ms = value;
            dut_limits.first_byte_timeout_ms = value;
         end
         default: begin
            gen_limits.byte_timeout_ms = value;
            dut_limits.byte_timeout_ms = value;
         end
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_limits(input int max_bytes, input int first_tmo, input int byte_tmo);
      csr_write(kbl_pkg::CSR_MAX_BLOCK, 16'(max_bytes));
      csr_write(kbl_pkg::CSR_FIRST_TMO, 16'(first_tmo));
      csr_write(kbl_pkg::CSR_BYTE_TMO, 16'(byte_tmo));
   endtask

   task automatic run_phase(input int quota, input int feed, input int drain);
      int stop_at;
      feed_mode = feed;
      drain_mode = drain;
      stop_at = made + quota;
      while (made < stop_at)
         gen_sequence();
      wait_drained();
   endtask

   // ---------------- request driver ----------------

   always @(negedge clock) begin
      if (!reset) begin
         if (req_chan.valid && !req_beat_taken) begin
            // hold the beat until it is taken
         end else if (gap_left != 0) begin
            gap_left <= gap_left - 1;
            req_chan.valid <= 1'b0;
         end else if (link_events.size() != 0) begin
            next_req = link_events.pop_front();
            req_chan.valid <= 1'b1;
            req_chan.op <= next_req.op;
            req_chan.line_byte <= next_req.line_byte;
            req_chan.expected_size <= next_req.expected_size;
            req_chan.send_data <= next_req.send_data;
            req_chan.send_last <= next_req.send_last;
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 16);
               gap_left <= (feed_mode == 0) ? 0 :
                           (feed_mode == 1) ? (($urandom_range(0, 3) == 0) ?
                                               $urandom_range(1, 3) : 0) :
                           $urandom_range(0, 12);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // ---------------- result sink stall pattern ----------------

   always @(negedge clock) begin
      if (!reset) begin
         if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            rsp_chan.ready <= 1'b0;
         end else if (flow_left != 0) begin
            flow_left <= flow_left - 1;
            rsp_chan.ready <= 1'b1;
         end else begin
            rsp_chan.ready <= 1'b1;
            flow_left <= $urandom_range(0, 24);
            stall_left <= (drain_mode == 0) ? 0 :
                          (drain_mode == 1) ? $urandom_range(0, 3) : $urandom_range(1, 15);
         end
      end
   end

   // ---------------- monitor ----------------

   always @(posedge clock) begin
      if (reset) begin
         req_beat_taken <= 1'b0;
      end else begin
         req_beat_taken <= req_chan.valid && req_chan.ready;
         if (req_chan.valid && req_chan.ready) begin
            seen_req.op = req_chan.op;
            seen_req.line_byte = req_chan.line_byte;
            seen_req.expected_size = req_chan.expected_size;
            seen_req.send_data = req_chan.send_data;
            seen_req.send_last = req_chan.send_last;
            link_results.push_back(link_step(dut_link, dut_limits, seen_req));
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (link_results.size() == 0) begin
               note("result beat with nothing outstanding");
            end else begin
               want_rsp = link_results.pop_front();
               check_field("tx_valid", 9'(rsp_chan.tx_valid), 9'(want_rsp.tx_valid));
               check_field("tx_byte", 9'(rsp_chan.tx_byte), 9'(want_rsp.tx_byte));
               check_field("rx_valid", 9'(rsp_chan.rx_valid), 9'(want_rsp.rx_valid));
               check_field("rx_byte", 9'(rsp_chan.rx_byte), 9'(want_rsp.rx_byte));
               check_field("rx_last", 9'(rsp_chan.rx_last), 9'(want_rsp.rx_last));
               check_field("status", 9'(rsp_chan.status), 9'(want_rsp.status));
               check_field("block_count", 9'(rsp_chan.block_count),
                           9'(want_rsp.block_count));
            end
         end
      end
   end

   // ---------------- test sequence ----------------

   initial begin
      req_chan.valid = 1'b0;
      req_chan.op = kbl_pkg::OP_START;
      req_chan.line_byte = '0;
      req_chan.expected_size = '0;
      req_chan.send_data = '0;
      req_chan.send_last = 1'b0;
      rsp_chan.ready = 1'b0;
      csr_we = 1'b0;
      csr_index = kbl_pkg::CSR_MAX_BLOCK;
      csr_wdata = '0;
      link_reset(gen_link, gen_limits);
      link_reset(dut_link, dut_limits);
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed pass at reset limits
      put_op(kbl_pkg::OP_TICK, 8'h00, 9'd0);
      put_op(kbl_pkg::OP_RX, 8'hA5, 9'd0);
      put_op(kbl_pkg::OP_START, 8'h00, 9'd65);
      put_op(kbl_pkg::OP_START, 8'hFF, 9'd256);
      put_op(kbl_pkg::OP_START, 8'h00, 9'd511);
      put_op(kbl_pkg::OP_START, 8'h00, 9'd2);
      put_op(kbl_pkg::OP_SEND, 8'h12, 9'd1);
      put_op(kbl_pkg::OP_RX, 8'h00, 9'd0);
      put_op(kbl_pkg::OP_RX, 8'hFF, 9'd0);
      put_op(kbl_pkg::OP_START, 8'h00, 9'd0);
      put_op(kbl_pkg::OP_RX, 8'hFF, 9'd0);
      put_op(kbl_pkg::OP_START, 8'h00, 9'd0);
      put_op(kbl_pkg::OP_RX, 8'h03, 9'd0);
      put_op(kbl_pkg::OP_RX, 8'h55, 9'd0);
      put_op(kbl_pkg::OP_START, 8'h00, 9'd0);
      put_op(kbl_pkg::OP_RX, 8'h02, 9'd0);
      put_op(kbl_pkg::OP_RX, gen_link.counter, 9'd0);
      put_op(kbl_pkg::OP_TICK, 8'h00, 9'd0);
      put_op(kbl_pkg::OP_RX, 8'hC3, 9'd0);
      put_op(kbl_pkg::OP_SEND, 8'h5A, 9'd0);
      put_op(kbl_pkg::OP_RX, 8'h00, 9'd0);
      put_op(kbl_pkg::OP_SEND, 8'hA5, 9'd0);
      put_op(kbl_pkg::OP_RX, 8'h5A, 9'd0);
      put_op(kbl_pkg::OP_SEND, 8'hFF, 9'd1);
      put_op(kbl_pkg::OP_START, 8'h00, 9'd0);
      put_op(kbl_pkg::OP_START, 8'h00, 9'd1);
      put_op(kbl_pkg::OP_RX, 8'h80, 9'd0);
      run_phase(300, 1, 1);

      set_limits(256, 65535, 65535);
      // enough single-beat sends to wrap the block counter
      repeat (260) put_op(kbl_pkg::OP_SEND, 8'($urandom_range(0, 255)), 9'd1);
      run_phase(250, 0, 0);

      set_limits(1, 1, 1);
      run_phase(250, 2, 2);

      set_limits(3, 0, 0);
      run_phase(200, 2, 0);

      set_limits($urandom_range(1, 256), $urandom_range(1, 30), $urandom_range(1, 30));
      run_phase(300, 1, 2);

      set_limits(64, 2000, 1000);
      run_phase(200, 0, 1);

      repeat (6) @(negedge clock);
      if (fail_count == 0 && link_results.size() == 0)
         $display("tb OK");
      else
         $display("tb NOT OK");
      $finish;
   end

   initial begin
      #4000000;
      $display("tb NOT OK");
      $finish;
   end

endmodule

/* files.f */
design/kbl_pkg.sv
design/kbl_if.sv
design/kbl_csr.sv
design/kbl_core.sv
design/keyword_block_link_engine.sv
tb/tb.sv
